>>> src/ftt_pkg.sv
// ----------------------------------------------------------------------------
// Fencing token table package
// Shared word types, field widths and mode and status codes.
// ----------------------------------------------------------------------------
package ftt_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int KEY_W   = 32;
    localparam int OWNER_W = 16;
    localparam int VALUE_W = 48;
    localparam int GEN_W   = 32;
    localparam int STAMP_W = 32;

    localparam logic [1:0] MODE_ISSUE  = 2'd0;
    localparam logic [1:0] MODE_REVOKE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_CHECK  = 2'd3;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_NOT_FOUND = 3'd1;
    localparam logic [2:0] STS_FULL      = 3'd2;
    localparam logic [2:0] STS_REVOKED   = 3'd3;
    localparam logic [2:0] STS_EXHAUSTED = 3'd4;

    localparam logic [VALUE_W-1:0] COUNTER_MAX  = {VALUE_W{1'b1}};
    localparam logic [VALUE_W-1:0] COUNTER_INIT = VALUE_W'(1);

    typedef struct packed {
        logic [1:0]         mode;
        logic [KEY_W-1:0]   resource_key;
        logic [OWNER_W-1:0] owner_id;
        logic [STAMP_W-1:0] now_seconds;
    } ftt_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [VALUE_W-1:0] fence_value;
        logic [GEN_W-1:0]   token_generation;
        logic [STAMP_W-1:0] issued_at;
        logic [OWNER_W-1:0] token_owner;
        logic [VALUE_W-1:0] next_value;
        logic               monotonic;
    } ftt_out_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [OWNER_W-1:0] owner;
        logic [VALUE_W-1:0] value;
        logic [GEN_W-1:0]   generation;
        logic [STAMP_W-1:0] stamp;
        logic               valid;
    } ftt_entry_t;

endpackage

>>> src/ftt_mem.sv
// ----------------------------------------------------------------------------
// Fencing token table entry store
// Single write port, single registered read port holding one entry per row.
// ----------------------------------------------------------------------------
module ftt_mem #(
    parameter int DEPTH = ftt_pkg::ENTRIES_DEF,
    parameter int AW    = 4
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  ftt_pkg::ftt_entry_t wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output ftt_pkg::ftt_entry_t rd_data
);
    import ftt_pkg::*;

    ftt_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/fencing_token_table.sv
// ----------------------------------------------------------------------------
// Fencing token table
// Resource table issuing, revoking, querying and checking fencing tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_ready / in_data carries one request word:
//   mode, resource key, owner and time stamp. Output channel out_valid /
//   out_ready / out_data carries one response word per request.
//   Each request scans every appended entry through one read port, one
//   entry per cycle, comparing key and token value in a single shared
//   compare stage, then an issue or revoke updates the matched or appended
//   entry when the response is loaded into the output register. in_ready
//   is high only while no request is in progress, so a new request is not
//   accepted until the last response has been loaded.
//   The response sits in an output register, so a new request is accepted
//   while an earlier response still waits; if the receiver stalls, the
//   following request finishes its scan and holds until the register frees.
//   Reset empties the table and sets the token counter to one; entry
//   storage itself is not cleared.
// ----------------------------------------------------------------------------
module fencing_token_table #(
    parameter int ENTRIES = ftt_pkg::ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ftt_pkg::ftt_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ftt_pkg::ftt_out_t out_data
);
    import ftt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    ftt_in_t            item_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [VALUE_W-1:0] counter_reg, counter_next;
    logic [CNT_W-1:0]   issue_idx_reg;
    logic               rvalid_reg;
    logic [IDX_W-1:0]   ridx_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    ftt_entry_t         hit_reg;
    logic               viol_reg;
    logic               out_valid_reg;
    ftt_out_t           out_reg;

    logic               rd_en;
    ftt_entry_t         rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    ftt_entry_t         wr_data;
    ftt_out_t           res;
    logic               load;
    logic               scan_done;
    logic               key_hit;
    logic               issue_ok;

    ftt_mem #(
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (issue_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign rd_en     = (state_reg == S_SCAN) && (issue_idx_reg != count_reg);
    assign scan_done = (issue_idx_reg == count_reg) && !rvalid_reg;
    assign key_hit   = rvalid_reg && (rd_data.key == item_reg.resource_key);
    assign load      = (state_reg == S_DECIDE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        res          = '0;
        wr_en        = 1'b0;
        wr_addr      = hit_idx_reg;
        wr_data      = hit_reg;
        count_next   = count_reg;
        counter_next = counter_reg;
        issue_ok     = 1'b0;
        case (item_reg.mode)
            MODE_ISSUE:
            begin
                if (!found_reg && (count_reg == CNT_W'(ENTRIES)))
                begin
                    res.status = STS_FULL;
                end
                else if (counter_reg == COUNTER_MAX)
                begin
                    res.status = STS_EXHAUSTED;
                end
                else
                begin
                    issue_ok           = 1'b1;
                    wr_en              = load;
                    wr_data.key        = item_reg.resource_key;
                    wr_data.owner      = item_reg.owner_id;
                    wr_data.value      = counter_reg;
                    wr_data.generation = found_reg ? hit_reg.generation + GEN_W'(1)
                                                   : GEN_W'(1);
                    wr_data.stamp      = item_reg.now_seconds;
                    wr_data.valid      = 1'b1;
                    counter_next       = counter_reg + VALUE_W'(1);
                    if (!found_reg)
                    begin
                        wr_addr    = count_reg[IDX_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                    res.status = STS_OK;
                end
            end
            MODE_REVOKE:
            begin
                if (!found_reg)
                begin
                    res.status = STS_NOT_FOUND;
                end
                else
                begin
                    wr_en         = load;
                    wr_data.valid = 1'b0;
                    res.status    = STS_OK;
                end
            end
            MODE_QUERY:
            begin
                if (!found_reg)
                begin
                    res.status = STS_NOT_FOUND;
                end
                else
                begin
                    res.status = hit_reg.valid ? STS_OK : STS_REVOKED;
                end
            end
            default:
            begin
                res.status = STS_OK;
            end
        endcase
        if ((item_reg.mode != MODE_CHECK) && (res.status == STS_OK || res.status == STS_REVOKED))
        begin
            res.fence_value      = wr_data.value;
            res.token_generation = wr_data.generation;
            res.issued_at        = wr_data.stamp;
            res.token_owner      = wr_data.owner;
        end
        res.next_value = counter_next;
        res.monotonic  = (count_next <= CNT_W'(1)) || !viol_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            counter_reg   <= COUNTER_INIT;
            issue_idx_reg <= '0;
            rvalid_reg    <= 1'b0;
            found_reg     <= 1'b0;
            viol_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rd_en;
            if (state_reg == S_IDLE && in_valid)
            begin
                issue_idx_reg <= '0;
                found_reg     <= 1'b0;
                viol_reg      <= 1'b0;
            end
            if (rd_en)
            begin
                issue_idx_reg <= issue_idx_reg + CNT_W'(1);
            end
            if (key_hit && !found_reg)
            begin
                found_reg <= 1'b1;
            end
            // flag any live token at or above the counter
            if (rvalid_reg && rd_data.valid && (rd_data.value >= counter_reg))
            begin
                viol_reg <= 1'b1;
            end
            if (load)
            begin
                count_reg     <= count_next;
                counter_reg   <= counter_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            item_reg <= in_data;
        end
        if (rd_en)
        begin
            ridx_reg <= issue_idx_reg[IDX_W-1:0];
        end
        if (key_hit && !found_reg)
        begin
            hit_idx_reg <= ridx_reg;
            hit_reg     <= rd_data;
        end
        if (load)
        begin
            out_reg <= res;
        end
    end

`ifndef SYNTH
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond table depth");

    a_counter_step : assert property (@(posedge clk) disable iff (!rst_n)
        (load && issue_ok) |=> (counter_reg == $past(counter_reg) + VALUE_W'(1)))
        else $error("counter did not advance on issue");

    a_counter_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !(load && issue_ok) |=> $stable(counter_reg))
        else $error("counter moved without an issue");

    a_monotonic : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.monotonic)
        else $error("live token at or above counter");

    a_write_decide : assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_DECIDE) && !rd_en)
        else $error("store written outside update");
`endif

endmodule
